>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MDF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define MDF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MDF_ASSERT(lbl, clk, rstn, prop)
`define MDF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/mdf_pkg.sv
// constants and types of the modular divider
`timescale 1ns / 1ps
package mdf_pkg;
    localparam int unsigned W = 30;
    localparam logic [W-1:0] MODULUS = 30'd998244353;
    localparam logic [31:0] MODULUS_X2 = 32'd1996488706;
    localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd998244353;
    localparam logic [30:0] MU = MU_FULL[30:0];
    localparam logic [W-1:0] EXPONENT = MODULUS - 30'd2;
    localparam int unsigned ROUNDS = W;
    localparam int unsigned MM_LAT = 4;
    typedef logic [W-1:0] t_res;
endpackage

>>> rtl/core/mdf_modmul.sv
// four stage barrett modular multiplier
`timescale 1ns / 1ps
module mdf_modmul (
    input  logic          i_clk,
    input  mdf_pkg::t_res i_a,
    input  mdf_pkg::t_res i_b,
    output mdf_pkg::t_res o_res
);
    import mdf_pkg::*;

    logic [59:0] r_p;
    logic [61:0] r_q;
    logic [31:0] r_plo;
    logic [31:0] r_r;
    t_res        r_res;
    logic [60:0] qm;
    logic [31:0] n_red;

    assign qm = 61'(r_q[61:31]) * 61'(MODULUS);

    always_comb begin
        if (r_r >= MODULUS_X2) begin
            n_red = r_r - MODULUS_X2;
        end else if (r_r >= 32'(MODULUS)) begin
            n_red = r_r - 32'(MODULUS);
        end else begin
            n_red = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= 60'(i_a) * 60'(i_b);
        r_q   <= 62'(r_p[59:29]) * 62'(MU);
        r_plo <= r_p[31:0];
        r_r   <= r_plo - qm[31:0];
        r_res <= n_red[W-1:0];
    end

    assign o_res = r_res;
endmodule

>>> rtl/core/mdf_round.sv
// one square and multiply round of the exponentiation
`timescale 1ns / 1ps
module mdf_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_use_mul,
    input  logic          i_vld,
    input  mdf_pkg::t_res i_acc,
    input  mdf_pkg::t_res i_base,
    output logic          o_vld,
    output mdf_pkg::t_res o_acc,
    output mdf_pkg::t_res o_base
);
    import mdf_pkg::*;

    t_res              r_acc_dly [MM_LAT];
    logic [MM_LAT-1:0] r_vld;
    t_res              prod;

    mdf_modmul u_mul (.i_clk(i_clk), .i_a(i_acc), .i_b(i_base), .o_res(prod));
    mdf_modmul u_sq  (.i_clk(i_clk), .i_a(i_base), .i_b(i_base), .o_res(o_base));

    always_ff @(posedge i_clk) begin
        r_acc_dly[0] <= i_acc;
        for (int i = 1; i < MM_LAT; i++) begin
            r_acc_dly[i] <= r_acc_dly[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MM_LAT-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[MM_LAT-1];
    assign o_acc = i_use_mul ? prod : r_acc_dly[MM_LAT-1];
endmodule

>>> rtl/core/modular_divide_fermat.sv
// top level of the modular divider modulo 998244353
// usage:
//   drive i_numerator and i_denominator and raise start for one cycle; an item
//   is taken at every clock edge where start is high and busy is low.
//   busy is always low, so a new item may enter in every cycle.
//   o_quotient = numerator * denominator^(p-2) mod p, with p = 998244353,
//   so a zero denominator gives zero.
//   the result shows on o_quotient for exactly one cycle with o_valid high,
//   once the item has passed through 30 square and multiply rounds, each
//   a 4 stage barrett multiplier (multiply, reciprocal multiply, back
//   multiply and subtract, final correction).
//   throughput is one item per cycle; results leave in the order taken.
//   the receiver cannot stall, so no result is ever held back.
//   reset clears all valid bits; items in flight are dropped.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module modular_divide_fermat (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mdf_pkg::t_res i_numerator,
    input  mdf_pkg::t_res i_denominator,
    output logic          o_valid,
    output mdf_pkg::t_res o_quotient
);
    import mdf_pkg::*;

    logic vld  [ROUNDS+1];
    t_res acc  [ROUNDS+1];
    t_res base [ROUNDS+1];

    assign busy    = 1'b0;
    assign vld[0]  = start & ~busy;
    assign acc[0]  = i_numerator;
    assign base[0] = i_denominator;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        mdf_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_use_mul(EXPONENT[g]),
            .i_vld    (vld[g]),
            .i_acc    (acc[g]),
            .i_base   (base[g]),
            .o_vld    (vld[g+1]),
            .o_acc    (acc[g+1]),
            .o_base   (base[g+1])
        );
    end

    assign o_valid    = vld[ROUNDS];
    assign o_quotient = acc[ROUNDS];

    `MDF_ASSERT(a_never_busy, i_clk, i_rst_n, !busy)
    `MDF_ASSERT_IMPL(a_result_reduced, i_clk, i_rst_n, o_valid, o_quotient < MODULUS)
    `MDF_ASSERT_NEXT(a_first_round_vld, i_clk, i_rst_n, start, g_round[0].u_round.r_vld[0])
endmodule
